>>> rtl/fbct_pkg.sv
package fbct_pkg;

  localparam int ADDR_W  = 32;
  localparam int BYTES_W = 16;
  localparam int SLOT_W  = 8;
  localparam int TOTAL_W = 64;

  typedef enum logic [1:0] {
    ST_UPDATED,
    ST_CREATED,
    ST_FULL,
    ST_BADLEN
  } status_t;

  // One packet as it travels down the row of cells.
  typedef struct packed {
    logic               valid;
    logic               done;
    logic               outgoing_dir;
    logic [ADDR_W-1:0]  remote;
    logic [BYTES_W-1:0] bytes;
    status_t            status;
    logic [SLOT_W-1:0]  entry_index;
    logic [TOTAL_W-1:0] outgoing_total;
    logic [TOTAL_W-1:0] incoming_total;
  } query_t;

endpackage

>>> rtl/fbct_in_if.sv
interface fbct_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_address;
  logic [31:0] dst_address;
  logic [15:0] packet_bytes;

  modport source (output valid, output src_address, output dst_address,
                  output packet_bytes, input ready);
  modport sink   (input valid, input src_address, input dst_address,
                  input packet_bytes, output ready);
endinterface

>>> rtl/fbct_out_if.sv
interface fbct_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  entry_index;
  logic        outgoing_dir;
  logic [31:0] remote_address;
  logic [63:0] outgoing_total;
  logic [63:0] incoming_total;

  modport source (output valid, output status, output entry_index, output outgoing_dir,
                  output remote_address, output outgoing_total, output incoming_total,
                  input ready);
  modport sink   (input valid, input status, input entry_index, input outgoing_dir,
                  input remote_address, input outgoing_total, input incoming_total,
                  output ready);
endinterface

>>> rtl/fbct_cell.sv
module fbct_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  fbct_pkg::query_t q_in,
  output fbct_pkg::query_t q_out
);

  localparam logic [fbct_pkg::SLOT_W-1:0] SLOT = fbct_pkg::SLOT_W'(CELL_IDX % 256);

  logic                            valid_r;
  logic                            valid_nxt;
  logic [fbct_pkg::ADDR_W-1:0]     remote_r;
  logic [fbct_pkg::ADDR_W-1:0]     remote_nxt;
  logic [fbct_pkg::TOTAL_W-1:0]    og_r;
  logic [fbct_pkg::TOTAL_W-1:0]    og_nxt;
  logic [fbct_pkg::TOTAL_W-1:0]    ic_r;
  logic [fbct_pkg::TOTAL_W-1:0]    ic_nxt;
  fbct_pkg::query_t                q_r;
  fbct_pkg::query_t                q_nxt;

  logic                            hit;
  logic                            claim;
  logic [fbct_pkg::TOTAL_W-1:0]    addend;
  logic [fbct_pkg::TOTAL_W-1:0]    total;

  assign hit   = valid_r && (remote_r == q_in.remote);
  assign claim = q_in.valid && !q_in.done && (hit || !valid_r);

  // A fresh entry starts from zero, so only a hit feeds the stored count.
  assign addend = !hit ? '0 : (q_in.outgoing_dir ? og_r : ic_r);
  assign total  = addend + fbct_pkg::TOTAL_W'(q_in.bytes);

  always_comb begin
    valid_nxt  = valid_r;
    remote_nxt = remote_r;
    og_nxt     = og_r;
    ic_nxt     = ic_r;
    q_nxt      = q_in;
    if (claim) begin
      valid_nxt  = 1'b1;
      remote_nxt = q_in.remote;
      og_nxt     = q_in.outgoing_dir ? total : (hit ? og_r : '0);
      ic_nxt     = q_in.outgoing_dir ? (hit ? ic_r : '0) : total;
      q_nxt.done           = 1'b1;
      q_nxt.status         = hit ? fbct_pkg::ST_UPDATED : fbct_pkg::ST_CREATED;
      q_nxt.entry_index    = SLOT;
      q_nxt.outgoing_total = og_nxt;
      q_nxt.incoming_total = ic_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      q_r.valid <= 1'b0;
    end else if (en) begin
      valid_r <= valid_nxt;
      q_r     <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      remote_r <= remote_nxt;
      og_r     <= og_nxt;
      ic_r     <= ic_nxt;
    end
  end

  assign q_out = q_r;

  // An allocated entry is never freed and never renamed.
  a_entry_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> valid_r)
    else $error("allocated entry lost its valid bit");

  a_remote_kept: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> $stable(remote_r))
    else $error("remote address of an allocated entry changed");

  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    (q_r.valid && !q_r.done) |-> (q_r.status == fbct_pkg::ST_FULL))
    else $error("unresolved item carries a resolved status");

endmodule

>>> rtl/fbct_out_skid.sv
module fbct_out_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  fbct_pkg::query_t in_item,
  output logic             room,
  fbct_out_if.source       out_chan
);

  fbct_pkg::query_t main_r;
  fbct_pkg::query_t main_nxt;
  fbct_pkg::query_t skid_r;
  fbct_pkg::query_t skid_nxt;
  logic             take;
  logic             pop;

  assign room = !skid_r.valid;
  assign take = in_item.valid && room;
  assign pop  = main_r.valid && out_chan.ready;

  always_comb begin
    main_nxt = main_r;
    skid_nxt = skid_r;
    if (pop || !main_r.valid) begin
      if (skid_r.valid) begin
        main_nxt       = skid_r;
        skid_nxt.valid = 1'b0;
      end else begin
        main_nxt       = in_item;
        main_nxt.valid = take;
      end
    end else if (take) begin
      // Output is stalled: park the item.
      skid_nxt = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_r.valid <= 1'b0;
      skid_r.valid <= 1'b0;
    end else begin
      main_r <= main_nxt;
      skid_r <= skid_nxt;
    end
  end

  assign out_chan.valid          = main_r.valid;
  assign out_chan.status         = main_r.status;
  assign out_chan.entry_index    = main_r.entry_index;
  assign out_chan.outgoing_dir   = main_r.outgoing_dir;
  assign out_chan.remote_address = main_r.remote;
  assign out_chan.outgoing_total = main_r.outgoing_total;
  assign out_chan.incoming_total = main_r.incoming_total;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_r.valid |-> main_r.valid)
    else $error("skid holds an item while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_r.valid && out_chan.ready) |=> !skid_r.valid)
    else $error("skid item not moved forward after output was taken");

endmodule

>>> rtl/flow_byte_counter_table.sv
// Channel   Dir  Handshake      Payload
// in_chan   in   valid/ready    src_address, dst_address, packet_bytes
// out_chan  out  valid/ready    status, entry_index, outgoing_dir, remote_address,
//                               outgoing_total, incoming_total
// cfg       in   cfg_we         cfg_wdata -> local_address
//
// One item enters per cycle while the row is not stalled; each cell of the row looks at it
// and registers it in turn on its way down, and the output register then holds the result.
// Reset empties the table at once; every cell owns its valid bit.
// A two-item output register and skid let one more item leave the row while the
// output is stalled; in_chan.ready then drops and the whole row holds.
module flow_byte_counter_table #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  fbct_in_if.sink     in_chan,
  fbct_out_if.source  out_chan
);

  logic [fbct_pkg::ADDR_W-1:0] local_address_r;
  logic                        row_en;
  logic                        dir;
  logic                        badlen;
  fbct_pkg::query_t            chain_q [TABLE_ENTRIES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= '0;
    end else if (cfg_we) begin
      local_address_r <= cfg_wdata;
    end
  end

  assign in_chan.ready = row_en;

  assign dir    = (in_chan.src_address == local_address_r);
  assign badlen = (in_chan.packet_bytes == '0);

  // Unresolved items default to table full; a cell that claims the item overwrites it.
  always_comb begin
    chain_q[0].valid          = in_chan.valid;
    chain_q[0].done           = badlen;
    chain_q[0].outgoing_dir   = dir;
    chain_q[0].remote         = dir ? in_chan.dst_address : in_chan.src_address;
    chain_q[0].bytes          = in_chan.packet_bytes;
    chain_q[0].status         = badlen ? fbct_pkg::ST_BADLEN : fbct_pkg::ST_FULL;
    chain_q[0].entry_index    = '0;
    chain_q[0].outgoing_total = '0;
    chain_q[0].incoming_total = '0;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    fbct_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (row_en),
      .q_in  (chain_q[i]),
      .q_out (chain_q[i+1])
    );
  end

  fbct_out_skid u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (chain_q[TABLE_ENTRIES]),
    .room     (row_en),
    .out_chan (out_chan)
  );

endmodule
